[rtl/core/atclp_pkg.sv]
package atclp_pkg;
    localparam int CMD_SLOTS_DEF   = 4;
    localparam int MOD_SLOTS_DEF   = 4;
    localparam int VALUE_SLOTS_DEF = 8;
    localparam int TOKEN_MAX_DEF   = 16;

    localparam logic [31:0] HASH_SEED = 32'd4321;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [4:0] PREFIX_LEN = 5'd3;
    localparam logic [3:0] RESULT_CAP = 4'd8;

    localparam logic [2:0] REG_PREFIX = 3'd0;
    localparam logic [2:0] REG_CMD0   = 3'd1;
    localparam logic [2:0] REG_CMD1   = 3'd2;
    localparam logic [2:0] REG_CMD2   = 3'd3;
    localparam logic [2:0] REG_CMD3   = 3'd4;
    localparam logic [2:0] REG_MODS   = 3'd5;
    localparam logic [2:0] REG_MINLEN = 3'd6;
    localparam logic [2:0] REG_MAXLEN = 3'd7;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PREFIX   = 9'b000000010,
        ST_COMMAND  = 9'b000000100,
        ST_MODIFIER = 9'b000001000,
        ST_DATA     = 9'b000010000,
        ST_NUMBER   = 9'b000100000,
        ST_ERROR    = 9'b001000000,
        ST_RESET    = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } state_t;

    // datapath commands from the controller
    typedef struct packed {
        logic hash_seed_a;   // hash = seed*5+c, len = 1
        logic hash_step;     // hash = hash*5+c, len++
        logic clr_token;
        logic clr_line;
        logic num_start;
        logic num_step;
        logic store;
        logic set_cmd;
        logic set_mod;
        logic emit_start;
        logic emit_err;
        logic emit_next;
    } dp_cmd_t;

    typedef struct packed {
        logic       prefix_done;  // len+1 >= 3
        logic       prefix_ok;
        logic       len_at_lim;
        logic       cmd_hit;
        logic       mod_hit;
        logic       out_busy;     // result waiting or store read in flight
        logic       emit_last;
    } dp_stat_t;
endpackage

[rtl/core/atclp_ctrl.sv]
module atclp_ctrl
    import atclp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [7:0] ch,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    state_t state_reg, state_next;
    logic is_digit, is_letter, is_eol, acc;

    assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
    assign is_letter = (ch >= CH_A) && (ch <= CH_Z);
    assign is_eol    = (ch == CH_LF) || (ch == CH_CR);
    // no new beat while results are pending
    assign in_ready  = !stat.out_busy && (state_reg != ST_EMIT);
    assign acc       = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (acc && ch == CH_A) begin
                    cmd.hash_seed_a = 1'b1;
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                if (acc) begin
                    if (stat.prefix_done) begin
                        if (stat.prefix_ok) begin
                            cmd.clr_token = 1'b1;
                            state_next = ST_COMMAND;
                        end else begin
                            state_next = ST_ERROR;
                        end
                    end else begin
                        cmd.hash_step = 1'b1;
                    end
                end
            end
            ST_COMMAND: begin
                if (acc) begin
                    if (!is_letter || stat.len_at_lim) begin
                        state_next = ST_ERROR;
                    end else if (stat.cmd_hit) begin
                        cmd.set_cmd = 1'b1;
                        cmd.clr_token = 1'b1;
                        state_next = ST_MODIFIER;
                    end else begin
                        cmd.hash_step = 1'b1;
                    end
                end
            end
            ST_MODIFIER: begin
                if (acc) begin
                    if (stat.mod_hit) begin
                        cmd.set_mod = 1'b1;
                        state_next = ST_DATA;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    if (is_digit || ch == CH_MINUS) begin
                        if (stat.len_at_lim) begin
                            state_next = ST_ERROR;
                        end else begin
                            cmd.num_start = 1'b1;
                            state_next = ST_NUMBER;
                        end
                    end else if (is_eol) begin
                        cmd.emit_start = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_NUMBER: begin
                if (acc) begin
                    if (is_digit) begin
                        if (stat.len_at_lim) begin
                            state_next = ST_ERROR;
                        end else begin
                            cmd.num_step = 1'b1;
                        end
                    end else if (is_eol) begin
                        cmd.store = 1'b1;
                        // store lands this edge; emission starts next cycle
                        state_next = ST_EMIT;
                    end else if (ch == CH_COMMA) begin
                        cmd.store = 1'b1;
                        cmd.clr_token = 1'b1;
                        state_next = ST_DATA;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_ERROR: begin
                if (acc) begin
                    cmd.clr_token = 1'b1;
                    cmd.emit_err = 1'b1;
                    state_next = ST_RESET;
                end
            end
            ST_EMIT: begin
                // walks the store, one result loaded per free output slot
                if (!stat.out_busy) begin
                    cmd.emit_next = 1'b1;
                    if (stat.emit_last) state_next = ST_RESET;
                end
            end
            ST_RESET: begin
                if (acc && is_eol) begin
                    cmd.clr_line = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule

[rtl/core/atclp_dp.sv]
module atclp_dp
    import atclp_pkg::*;
#(
    parameter int CMD_SLOTS   = CMD_SLOTS_DEF,
    parameter int MOD_SLOTS   = MOD_SLOTS_DEF,
    parameter int VALUE_SLOTS = VALUE_SLOTS_DEF,
    parameter int TOKEN_MAX   = TOKEN_MAX_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  ch,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [31:0] prefix_hash,
    input  logic [31:0] cmd_hash [4],
    input  logic [31:0] mod_chars,
    input  logic [4:0]  min_len,
    input  logic [4:0]  max_len,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    localparam int VW = $clog2(VALUE_SLOTS + 1);
    localparam int AW = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
    localparam logic [4:0] TOK_MAX = 5'(TOKEN_MAX);

    logic [4:0]  len_reg;
    logic [31:0] hash_reg, acc_reg;
    logic        neg_reg, ovf_reg;
    logic [1:0]  mcmd_reg, mmod_reg;
    logic [VW-1:0] total_reg;
    logic [31:0] store_mem [VALUE_SLOTS];
    logic [3:0]  k_reg;          // next result index
    logic        out_v_reg;
    logic [47:0] out_d_reg;
    logic        out_l_reg;
    logic        rd_v_reg;       // read data of store is in flight
    logic [31:0] rd_data_reg;
    logic        rd_last_reg;
    logic [2:0]  rd_k_reg;

    logic [31:0] hash_next, hash5;
    logic [4:0]  len_inc, lim;
    logic [3:0]  n_emit, tot4;
    logic [1:0]  cmd_idx, mod_idx;
    logic        cmd_hit, mod_hit;
    logic [31:0] sval;
    logic [3:0]  digit;

    assign hash5     = {hash_reg[29:0], 2'b00} + hash_reg;
    assign hash_next = hash5 + {24'd0, ch};
    assign len_inc   = len_reg + 5'd1;
    assign lim       = (max_len < TOK_MAX) ? max_len : TOK_MAX;
    assign digit     = 4'(ch - CH_0);
    assign sval      = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign tot4      = 4'(total_reg);
    assign n_emit    = (32'(total_reg) > 32'(RESULT_CAP)) ? RESULT_CAP : tot4;

    always_comb begin
        cmd_hit = 1'b0;
        cmd_idx = '0;
        for (int i = CMD_SLOTS - 1; i >= 0; i--) begin
            if (cmd_hash[i] == hash_next) begin
                cmd_hit = 1'b1;
                cmd_idx = 2'(i);
            end
        end
        if (len_inc < min_len) cmd_hit = 1'b0;
        mod_hit = 1'b0;
        mod_idx = '0;
        for (int i = MOD_SLOTS - 1; i >= 0; i--) begin
            if (mod_chars[8*i +: 8] == ch) begin
                mod_hit = 1'b1;
                mod_idx = 2'(i);
            end
        end
    end

    assign stat.prefix_done = (len_inc >= PREFIX_LEN);
    assign stat.prefix_ok   = (hash_next == prefix_hash);
    assign stat.len_at_lim  = (len_reg >= lim);
    assign stat.cmd_hit     = cmd_hit;
    assign stat.mod_hit     = mod_hit;
    assign stat.out_busy    = out_v_reg || rd_v_reg;
    assign stat.emit_last   = (n_emit == 4'd0) || (k_reg + 4'd1 >= n_emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            hash_reg  <= HASH_SEED;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            mcmd_reg  <= '0;
            mmod_reg  <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end else begin
            if (cmd.hash_seed_a) begin
                hash_reg <= hash_next;
                len_reg  <= 5'd1;
            end
            if (cmd.hash_step) begin
                hash_reg <= hash_next;
                len_reg  <= len_inc;
            end
            if (cmd.num_start) begin
                len_reg <= len_inc;
                neg_reg <= (ch == CH_MINUS);
                acc_reg <= (ch == CH_MINUS) ? 32'd0 : {28'd0, digit};
            end
            if (cmd.num_step) begin
                len_reg <= len_inc;
                acc_reg <= {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                           + {28'd0, digit};
            end
            if (cmd.set_cmd) mcmd_reg <= cmd_idx;
            if (cmd.set_mod) mmod_reg <= mod_idx;
            if (cmd.store) begin
                if (total_reg < VW'(VALUE_SLOTS)) total_reg <= total_reg + VW'(1);
                else                              ovf_reg <= 1'b1;
            end
            if (cmd.clr_token || cmd.clr_line) begin
                len_reg  <= '0;
                hash_reg <= HASH_SEED;
                acc_reg  <= '0;
                neg_reg  <= 1'b0;
            end
            if (cmd.clr_line) begin
                mcmd_reg  <= '0;
                mmod_reg  <= '0;
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.emit_start || cmd.store) k_reg <= '0;
            else if (cmd.emit_next)          k_reg <= k_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && total_reg < VW'(VALUE_SLOTS))
            store_mem[total_reg[AW-1:0]] <= sval;
        rd_data_reg <= store_mem[AW'(k_reg)];
        rd_last_reg <= stat.emit_last;
        rd_k_reg    <= k_reg[2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= cmd.emit_next;
            if (cmd.emit_err) begin
                out_v_reg <= 1'b1;
                out_d_reg <= {47'd0, 1'b1};
                out_l_reg <= 1'b1;
            end else if (rd_v_reg) begin
                out_v_reg <= 1'b1;
                out_l_reg <= rd_last_reg;
                if (n_emit == 4'd0)
                    out_d_reg <= {3'd0, ovf_reg, 4'd0, 32'd0, 3'd0,
                                  mmod_reg, mcmd_reg, 1'b0};
                else
                    out_d_reg <= {3'd0, ovf_reg, tot4, rd_data_reg, rd_k_reg,
                                  mmod_reg, mcmd_reg, 1'b0};
            end else if (out_v_reg && m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;
endmodule

[rtl/core/at_command_line_parser_top.sv]
// An end of line starts the result run after the store write; each result passes
// through a registered store read and then the output register.
// Throughput: one character per cycle; while results are pending the input stalls,
// and each result is read from the store, loaded and handed off before the next is read.
// Reset: aresetn synchronous, active low; sets config registers to defaults, clears parser state.
module at_command_line_parser_top
    import atclp_pkg::*;
#(
    parameter int COMMAND_SLOTS  = CMD_SLOTS_DEF,
    parameter int MODIFIER_SLOTS = MOD_SLOTS_DEF,
    parameter int VALUE_SLOTS    = VALUE_SLOTS_DEF,
    parameter int TOKEN_MAX      = TOKEN_MAX_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, cmd_slot, mod_slot, value_slot, arg_value, arg_count, args_dropped
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] prefix_reg, mods_reg;
    logic [31:0] cmd_reg [4];
    logic [4:0]  minl_reg, maxl_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            mods_reg   <= '0;
            for (int i = 0; i < 4; i++) cmd_reg[i] <= '0;
            minl_reg   <= 5'd1;
            maxl_reg   <= 5'd16;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_PREFIX: prefix_reg <= pwdata;
                REG_CMD0:   cmd_reg[0] <= pwdata;
                REG_CMD1:   cmd_reg[1] <= pwdata;
                REG_CMD2:   cmd_reg[2] <= pwdata;
                REG_CMD3:   cmd_reg[3] <= pwdata;
                REG_MODS:   mods_reg   <= pwdata;
                REG_MINLEN: minl_reg   <= pwdata[4:0];
                REG_MAXLEN: maxl_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_PREFIX: prdata = prefix_reg;
            REG_CMD0:   prdata = cmd_reg[0];
            REG_CMD1:   prdata = cmd_reg[1];
            REG_CMD2:   prdata = cmd_reg[2];
            REG_CMD3:   prdata = cmd_reg[3];
            REG_MODS:   prdata = mods_reg;
            REG_MINLEN: prdata = {27'd0, minl_reg};
            REG_MAXLEN: prdata = {27'd0, maxl_reg};
            default:    prdata = '0;
        endcase
    end

    atclp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .ch       (s_tdata),
        .stat     (stat),
        .cmd      (cmd)
    );

    atclp_dp #(
        .CMD_SLOTS   (COMMAND_SLOTS),
        .MOD_SLOTS   (MODIFIER_SLOTS),
        .VALUE_SLOTS (VALUE_SLOTS),
        .TOKEN_MAX   (TOKEN_MAX)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ch          (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .prefix_hash (prefix_reg),
        .cmd_hash    (cmd_reg),
        .mod_chars   (mods_reg),
        .min_len     (minl_reg),
        .max_len     (maxl_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );
endmodule

[test/at_command_line_parser_top_test.sv]
`timescale 1ns / 1ps

module at_command_line_parser_top_test
    import atclp_pkg::*;
();

    typedef enum logic [2:0] {
        PM_IDLE, PM_PREFIX, PM_COMMAND, PM_MODIFIER, PM_DATA, PM_NUMBER, PM_ERROR, PM_RESET
    } parse_mode_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  cmd_slot;
        logic [1:0]  mod_slot;
        logic [2:0]  value_slot;
        logic [31:0] arg_value;
        logic [3:0]  arg_count;
        logic        args_dropped;
        logic        last;
    } line_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    at_command_line_parser_top DUT (.*);

    always #4 aclk = ~aclk;

    // register shadow
    logic [31:0] prefix_reg, mods_reg;
    logic [31:0] cmd_reg [4];
    logic [4:0]  min_len, max_len;

    // parser shadow
    parse_mode_t pmode;
    logic [4:0]  tok_len;
    logic [31:0] run_hash, accum;
    logic        negative, dropped;
    logic [1:0]  hit_cmd, hit_mod;
    logic [31:0] values [8];
    logic [3:0]  n_values;

    line_result_t expected_results[$];
    int mismatches = 0;
    int tx_idle_pct = 0, rx_idle_pct = 0;

    // line vocabulary of the current setting
    byte   prefix_chars[3];
    string cmd_names[4];
    byte   mod_chars[4];

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge aclk) begin
        line_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[2:1], m_tdata[4:3], m_tdata[7:5], m_tdata[39:8],
                   m_tdata[43:40], m_tdata[44], m_tlast};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected st=%b cmd=%0d mod=%0d slot=%0d val=%h cnt=%0d drop=%b last=%b, got st=%b cmd=%0d mod=%0d slot=%0d val=%h cnt=%0d drop=%b last=%b",
                            want.status, want.cmd_slot, want.mod_slot, want.value_slot,
                            want.arg_value, want.arg_count, want.args_dropped, want.last,
                            got.status, got.cmd_slot, got.mod_slot, got.value_slot,
                            got.arg_value, got.arg_count, got.args_dropped, got.last);
                end
            end
        end
    end

    function automatic logic [31:0] name_hash(string s);
        logic [31:0] h = HASH_SEED;
        for (int i = 0; i < s.len(); i++) h = h * 5 + s[i];
        return h;
    endfunction

    function automatic logic [4:0] token_cap();
        return (max_len < 5'd16) ? max_len : 5'd16;
    endfunction

    function automatic bit is_eol(logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    task automatic clear_token();
        tok_len = 0; run_hash = HASH_SEED; accum = 0; negative = 0;
    endtask

    task automatic keep_value();
        if (n_values < 8) begin
            values[n_values] = negative ? (32'd0 - accum) : accum;
            n_values++;
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic emit_line();
        line_result_t r;
        if (n_values == 0) begin
            r = '{1'b0, hit_cmd, hit_mod, 3'd0, 32'd0, 4'd0, dropped, 1'b1};
            expected_results.push_back(r);
        end
        for (int k = 0; k < n_values; k++) begin
            r = '{1'b0, hit_cmd, hit_mod, k[2:0], values[k], n_values, dropped,
                  (k + 1 == n_values)};
            expected_results.push_back(r);
        end
        pmode = PM_RESET;
    endtask

    task automatic predict_char(logic [7:0] c);
        bit digit;
        digit = c >= CH_0 && c <= CH_9;
        case (pmode)
            PM_IDLE: if (c == CH_A) begin
                run_hash = HASH_SEED * 5 + c; tok_len = 1; pmode = PM_PREFIX;
            end
            PM_PREFIX: begin
                run_hash = run_hash * 5 + c;
                tok_len++;
                if (tok_len >= 3) begin
                    if (run_hash == prefix_reg) begin
                        clear_token(); pmode = PM_COMMAND;
                    end else pmode = PM_ERROR;
                end
            end
            PM_COMMAND: begin
                if (c < CH_A || c > CH_Z || tok_len >= token_cap()) pmode = PM_ERROR;
                else begin
                    run_hash = run_hash * 5 + c;
                    tok_len++;
                    if (tok_len >= min_len) begin
                        for (int i = 0; i < 4; i++) begin
                            if (pmode == PM_COMMAND && cmd_reg[i] == run_hash) begin
                                hit_cmd = 2'(i); clear_token(); pmode = PM_MODIFIER;
                            end
                        end
                    end
                end
            end
            PM_MODIFIER: begin
                pmode = PM_ERROR;
                for (int i = 3; i >= 0; i--) begin
                    if (mods_reg[8*i +: 8] == c) begin
                        hit_mod = 2'(i); pmode = PM_DATA;
                    end
                end
            end
            PM_DATA: begin
                if (digit || c == CH_MINUS) begin
                    if (tok_len >= token_cap()) pmode = PM_ERROR;
                    else begin
                        tok_len++;
                        negative = (c == CH_MINUS);
                        accum = negative ? 32'd0 : 32'(c - CH_0);
                        pmode = PM_NUMBER;
                    end
                end else if (is_eol(c)) emit_line();
                else pmode = PM_ERROR;
            end
            PM_NUMBER: begin
                if (digit) begin
                    if (tok_len >= token_cap()) pmode = PM_ERROR;
                    else begin
                        tok_len++;
                        accum = accum * 10 + 32'(c - CH_0);
                    end
                end else if (is_eol(c)) begin
                    keep_value(); emit_line();
                end else if (c == CH_COMMA) begin
                    keep_value(); clear_token(); pmode = PM_DATA;
                end else pmode = PM_ERROR;
            end
            PM_ERROR: begin
                clear_token();
                pmode = PM_RESET;
                expected_results.push_back('{1'b1, 2'd0, 2'd0, 3'd0, 32'd0, 4'd0, 1'b0, 1'b1});
            end
            default: if (is_eol(c)) begin
                clear_token();
                hit_cmd = 0; hit_mod = 0; n_values = 0; dropped = 0;
                pmode = PM_IDLE;
            end
        endcase
    endtask

    task automatic send_char(logic [7:0] c);
        if ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        // ready only moves at the rising edge, so it is steady here
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        predict_char(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // bring the parser back to idle and let the result run finish
    task automatic settle();
        while (pmode != PM_IDLE) send_char(CH_LF);
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge aclk) penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PREFIX: prefix_reg = v;
            REG_CMD0:   cmd_reg[0] = v;
            REG_CMD1:   cmd_reg[1] = v;
            REG_CMD2:   cmd_reg[2] = v;
            REG_CMD3:   cmd_reg[3] = v;
            REG_MODS:   mods_reg = v;
            REG_MINLEN: min_len = v[4:0];
            default:    max_len = v[4:0];
        endcase
    endtask

    function automatic string letters(int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(CH_Z, CH_A)))};
        return s;
    endfunction

    task automatic set_vocabulary(int lo, int hi);
        string p;
        logic [2:0] cmd_regs[4];
        prefix_chars[0] = CH_A;
        prefix_chars[1] = $urandom_range(126, 33);
        prefix_chars[2] = $urandom_range(126, 33);
        p = {string'(prefix_chars[0]), string'(prefix_chars[1]), string'(prefix_chars[2])};
        cmd_regs = '{REG_CMD0, REG_CMD1, REG_CMD2, REG_CMD3};
        settle();
        write_reg(REG_MINLEN, lo);
        write_reg(REG_MAXLEN, hi);
        write_reg(REG_PREFIX, name_hash(p));
        for (int i = 0; i < 4; i++) begin
            cmd_names[i] = letters($urandom_range(hi, lo));
            write_reg(cmd_regs[i], name_hash(cmd_names[i]));
            mod_chars[i] = $urandom_range(126, 33);
        end
        write_reg(REG_MODS, {mod_chars[3], mod_chars[2], mod_chars[1], mod_chars[0]});
    endtask

    function automatic string line_head(int cmd, int md);
        return {string'(prefix_chars[0]), string'(prefix_chars[1]), string'(prefix_chars[2]),
                cmd_names[cmd], string'(mod_chars[md])};
    endfunction

    task automatic test_directed();
        string h;
        set_vocabulary(1, 16);
        h = line_head(0, 0);
        send_text({h, "\n\n"});                              // no values
        send_text({h, "0,-,-2147483648,2147483647\r\n"});     // lone minus, extremes
        send_text({line_head(3, 3), "99999999999999\n\n"});  // wraps
        send_text({line_head(1, 2), "1,2,3,4,5,6,7,8,9,10\n\n"}); // store full
        send_text({h, "1-2\n\n"});                           // minus inside number
        send_text({h, "7,,\n\n"});
        send_text({"AT", cmd_names[0], "\n\n"});             // bad prefix (almost surely)
        send_text({line_head(2, 1), "5\nxyz\377\000\n"});     // reset mode ignores junk
        send_text({string'(prefix_chars[0]), string'(prefix_chars[1]),
                   string'(prefix_chars[2]), "a1\n\n"});     // non-letter in command
        send_text({h, "12345678901234567\n\n"});             // number too long
        settle();
        // shortest token limit
        set_vocabulary(1, 1);
        send_text({line_head(1, 0), "5\n\n"});
        send_text({line_head(0, 0), "55,-\n\n"});
        send_text({string'(prefix_chars[0]), string'(prefix_chars[1]),
                   string'(prefix_chars[2]), "QQ\n\n"});
        settle();
    endtask

    task automatic random_line(output int n_sent);
        string s;
        int nv, lim;
        lim = token_cap();
        s = line_head($urandom_range(3), $urandom_range(3));
        if ($urandom_range(9) == 0) s = {s.substr(0, 2), letters($urandom_range(lim + 1, 1))};
        nv = $urandom_range(5);
        for (int v = 0; v < nv; v++) begin
            int nd;
            if (v) s = {s, ","};
            nd = $urandom_range((lim < 5) ? lim : 5, 1);
            if ($urandom_range(3) == 0) begin
                s = {s, "-"}; nd--;
            end
            for (int d = 0; d < nd; d++) s = {s, string'(byte'($urandom_range(CH_9, CH_0)))};
        end
        if ($urandom_range(14) == 0) s = {s, string'(byte'($urandom_range(255)))};
        if ($urandom_range(1)) s = {s, "\r\n"};
        else                   s = {s, "\n\n"};
        send_text(s);
        n_sent = s.len();
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int lo, int hi, int n_chars);
        int sent = 0;
        int n_line;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_vocabulary(lo, hi);
        while (sent < n_chars) begin
            if ($urandom_range(4) == 0) begin
                for (int i = $urandom_range(6, 1); i > 0; i--) begin
                    send_char(8'($urandom_range(255)));
                    sent++;
                end
            end else begin
                random_line(n_line);
                sent += n_line;
            end
        end
        settle();
    endtask

    initial begin
        prefix_reg = 0; mods_reg = 0; min_len = 1; max_len = 16;
        for (int i = 0; i < 4; i++) cmd_reg[i] = 0;
        pmode = PM_IDLE; hit_cmd = 0; hit_mod = 0; n_values = 0; dropped = 0;
        clear_token();
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        tx_idle_pct = 17; rx_idle_pct = 85;
        test_directed();
        test_random(17, 85, 1, 16, 25);
        test_random(85, 17, 2, 5, 25);
        test_random(0, 0, 16, 16, 25);
        test_random(0, 0, 1, 3, 15);
        wait (expected_results.size() == 0);
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
rtl/core/atclp_pkg.sv
rtl/core/atclp_ctrl.sv
rtl/core/atclp_dp.sv
rtl/core/at_command_line_parser_top.sv
test/at_command_line_parser_top_test.sv
